FILE: sv/color_blob_steering_assert.svh
// Assertion macros shared by the block's RTL files.
// Each macro takes a label, a condition and a consequence; clk and rst come
// from the module that uses it.
`ifndef COLOR_BLOB_STEERING_ASSERT_SVH
`define COLOR_BLOB_STEERING_ASSERT_SVH

// Consequence must hold in the same cycle as the condition.
`define CBS_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// Consequence must hold in the cycle after the condition.
`define CBS_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/cbs_pkg.sv
`default_nettype none
package cbs_pkg;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int COL_W      = 10;
  localparam int CHAN_W     = 8;
  localparam int WIDTH_W    = 11;
  localparam int HALF_W     = WIDTH_W - 1;
  localparam int COUNT_W    = 21;
  localparam int SPEED_W    = 7;
  localparam int DRIVE_W    = 16;
  localparam int SUM_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LAST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN     = 3'd6;

  // Register reset values
  localparam logic [CHAN_W-1:0]  RST_RED_MIN       = 8'd200;
  localparam logic [CHAN_W-1:0]  RST_GREEN_MAX     = 8'd60;
  localparam logic [CHAN_W-1:0]  RST_BLUE_MAX      = 8'd60;
  localparam logic [WIDTH_W-1:0] RST_IMAGE_WIDTH   = 11'd320;
  localparam logic [COUNT_W-1:0] RST_MIN_COUNT     = 21'd10;
  localparam logic [SPEED_W-1:0] RST_FORWARD_SPEED = 7'd60;
  localparam logic [SPEED_W-1:0] RST_TURN_GAIN     = 7'd30;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Divider: dividend, divisor, quotient widths
  localparam int DIV_NW    = 48;
  localparam int DIV_DW    = 32;
  localparam int DIV_QW    = 18;
  localparam int DIV_SW    = DIV_DW + DIV_QW - 1;
  localparam int DIV_CNT_W = $clog2(DIV_QW + 1);

  // Multiplier operand widths
  localparam int MUL_AW = SUM_W;
  localparam int MUL_BW = HALF_W;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int NUM_W  = SUM_W + SPEED_W;

  // Smoothing word widths
  localparam int SM_NW = DRIVE_W + 3;
  localparam int SM_MW = SM_NW - 1;

  // Divide by five: multiply by ceil(2^18 / 5) and keep bits 18 and up;
  // exact for every magnitude below 2^18
  localparam int                    SM_RND     = 2;
  localparam int                    SM_RECIP_W = 16;
  localparam logic [SM_RECIP_W-1:0] SM_RECIP   = 16'd52429;
  localparam int                    SM_SHIFT   = 18;
  localparam int                    SM_PW      = SM_MW + SM_RECIP_W;

  localparam logic signed [DRIVE_W-1:0] DRIVE_POS_MAX = 16'sh7FFF;
  localparam logic signed [DRIVE_W-1:0] DRIVE_NEG_MAX = 16'sh8000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [COL_W-1:0]  column;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_x;
    logic signed [DRIVE_W-1:0] drive_y;
    logic signed [DRIVE_W-1:0] drive_turn;
    logic [COUNT_W-1:0]        blob_pixels;
  } res_t;

  typedef struct packed {
    logic acc;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_TEST,
    ST_NUM,
    ST_TLOAD,
    ST_TDIV,
    ST_SLOAD,
    ST_SMUL,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: sv/cbs_accum.sv
`default_nettype none
module cbs_accum
  import cbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire acc_ctrl_t          ctrl,
  input  wire pix_t               pix,
  input  wire logic [CHAN_W-1:0]  red_min,
  input  wire logic [CHAN_W-1:0]  green_max,
  input  wire logic [CHAN_W-1:0]  blue_max,
  output logic      [SUM_W-1:0]   col_sum,
  output logic      [COUNT_W-1:0] pix_count
);

  logic hit;

  // Color window test; a full counter drops further pixels
  assign hit = (pix.red > red_min) && (pix.green < green_max) &&
               (pix.blue < blue_max) && (pix_count != COUNT_MAX);

  // Accumulate column sum and count; clear after each frame
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      col_sum   <= '0;
      pix_count <= '0;
    end else if (ctrl.acc && hit) begin
      col_sum   <= col_sum + SUM_W'(pix.column);
      pix_count <= pix_count + 1'b1;
    end
  end

endmodule
`default_nettype wire

FILE: sv/cbs_div.sv
`default_nettype none
module cbs_div
  import cbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_NW-1:0]    rem;
  logic [DIV_SW-1:0]    dsh;
  logic [DIV_QW-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 done;
  logic                 ge;

  // One restoring step per cycle, quotient MSB first
  assign ge = {{(DIV_SW-DIV_NW){1'b0}}, rem} >= dsh;

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1)) && !req.start;
      if (req.start) begin
        cnt <= DIV_CNT_W'(DIV_QW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Load operands, then subtract and shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= {req.den, {(DIV_QW-1){1'b0}}};
      quo <= '0;
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= rem - dsh[DIV_NW-1:0];
      end
      quo <= {quo[DIV_QW-2:0], ge};
      dsh <= dsh >> 1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule
`default_nettype wire

FILE: sv/color_blob_steering.sv
`default_nettype none
// Color blob steering: counts pixels inside a color window, finds the blob's
// column offset at frame end and produces smoothed Q8.8 drive targets.
// Channels: pix_valid/pix_stall/pix_data carries one pixel or command beat;
// res_valid/res_stall/res_data carries one result beat per frame end or tick;
// cfg_valid/cfg_ready/cfg_index/cfg_data writes a register (cfg_ready is
// always high). Pixel beats (cmd 0) can stream every cycle while the block is
// idle. A tick (cmd 2) runs three smoothing lanes, each through SLOAD and
// SMUL, then loads the output register in DONE. A frame end (cmd 1) first
// forms the centre product in DEN and runs the window test in TEST; when the
// turn is steered it adds the gain product (NUM), the divider load (TLOAD)
// and the divider (TDIV), one quotient bit per cycle, before the lanes.
// pix_stall is high while these sequences run. A finished result waits in an
// output register, and pixel beats are taken while it waits; a second result
// holds in the last step until the receiver takes the first. Reset restores
// register defaults and zeros the accumulators, targets and smoothed values.
module color_blob_steering
  import cbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pix_valid,
  output logic                       pix_stall,
  input  wire pix_t                  pix_data,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output res_t                       res_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  `include "color_blob_steering_assert.svh"

  state_t state, state_next;

  logic [CHAN_W-1:0]  red_min, green_max, blue_max;
  logic [WIDTH_W-1:0] image_width;
  logic [COUNT_W-1:0] min_count;
  logic [SPEED_W-1:0] forward_speed, turn_gain;

  logic [SUM_W-1:0]   col_sum;
  logic [COUNT_W-1:0] pix_count;
  acc_ctrl_t          acc_ctrl;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [HALF_W-1:0]  half;
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_p;
  logic               mul_gain;

  logic [SUM_W-1:0]   den;
  logic [SUM_W-1:0]   mag;
  logic               neg;
  logic [NUM_W-1:0]   num;
  logic [COUNT_W-1:0] blob;
  logic [1:0]         lane;
  logic               sm_neg;
  logic [SM_MW-1:0]   sm_r;

  logic signed [DRIVE_W-1:0] tgt [3];
  logic signed [DRIVE_W-1:0] smooth [3];

  logic                pix_accept;
  logic                res_load;
  logic signed [SUM_W:0] diff_w;
  logic [SUM_W-1:0]    mag_w;
  logic [SUM_W+2:0]    five_mag;
  logic                centred;
  logic                steer;
  logic signed [SM_NW-1:0] sm_n;
  logic [SM_MW-1:0]    sm_m;
  logic [SM_PW-1:0]    sm_p;
  logic [DRIVE_W-1:0]  sm_q;
  logic [DRIVE_W-1:0]  sm_qn;
  logic [DIV_QW-1:0]   quo_neg;
  logic signed [DRIVE_W-1:0] turn_w;

  assign cfg_ready  = 1'b1;
  assign pix_stall  = (state != ST_IDLE);
  assign pix_accept = pix_valid && !pix_stall;

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      red_min       <= RST_RED_MIN;
      green_max     <= RST_GREEN_MAX;
      blue_max      <= RST_BLUE_MAX;
      image_width   <= RST_IMAGE_WIDTH;
      min_count     <= RST_MIN_COUNT;
      forward_speed <= RST_FORWARD_SPEED;
      turn_gain     <= RST_TURN_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RED_MIN:       red_min       <= cfg_data[CHAN_W-1:0];
        REG_GREEN_MAX:     green_max     <= cfg_data[CHAN_W-1:0];
        REG_BLUE_MAX:      blue_max      <= cfg_data[CHAN_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[WIDTH_W-1:0];
        REG_MIN_COUNT:     min_count     <= cfg_data[COUNT_W-1:0];
        REG_FORWARD_SPEED: forward_speed <= cfg_data[SPEED_W-1:0];
        REG_TURN_GAIN:     turn_gain     <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  cbs_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (acc_ctrl),
    .pix       (pix_data),
    .red_min   (red_min),
    .green_max (green_max),
    .blue_max  (blue_max),
    .col_sum   (col_sum),
    .pix_count (pix_count)
  );

  cbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Image centre, never below one
  assign half = (image_width[WIDTH_W-1:1] == '0) ? HALF_W'(1) : image_width[WIDTH_W-1:1];

  // Shared multiplier: half * count, then |offset| * gain
  assign mul_a = mul_gain ? mag : MUL_AW'(pix_count);
  assign mul_b = mul_gain ? MUL_BW'(turn_gain) : half;
  assign mul_p = mul_a * mul_b;

  // Offset from centre and the centred window test
  assign diff_w   = $signed({1'b0, col_sum}) - $signed({1'b0, den});
  assign mag_w    = diff_w[SUM_W] ? SUM_W'(-diff_w) : diff_w[SUM_W-1:0];
  assign five_mag = {mag_w, 2'b00} + (SUM_W+3)'(mag_w);
  assign centred  = (pix_count != '0) && (five_mag < (SUM_W+3)'(den));
  assign steer    = pix_count > min_count;

  // Smoothing word for the current lane: 4*s + t
  assign sm_n = (SM_NW'(smooth[lane]) <<< 2) + SM_NW'(tgt[lane]);
  assign sm_m = sm_n[SM_NW-1] ? SM_MW'(-sm_n) : sm_n[SM_MW-1:0];

  // Rounded magnitude divided by five through the reciprocal
  assign sm_p  = SM_PW'(sm_r) * SM_PW'(SM_RECIP);
  assign sm_q  = sm_p[SM_SHIFT +: DRIVE_W];
  assign sm_qn = '0 - sm_q;

  // Signed, saturated turn from the quotient magnitude
  assign quo_neg = '0 - div_rsp.quo;
  always_comb begin
    if (neg) begin
      turn_w = (div_rsp.quo > DIV_QW'(32768)) ? DRIVE_NEG_MAX : quo_neg[DRIVE_W-1:0];
    end else begin
      turn_w = (div_rsp.quo > DIV_QW'(32767)) ? DRIVE_POS_MAX
                                              : $signed(div_rsp.quo[DRIVE_W-1:0]);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pix_accept) begin
          case (pix_data.cmd)
            CMD_LAST: state_next = ST_DEN;
            CMD_TICK: state_next = ST_SLOAD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEN:   state_next = ST_TEST;
      ST_TEST:  state_next = (!centred && steer) ? ST_NUM : ST_SLOAD;
      ST_NUM:   state_next = ST_TLOAD;
      ST_TLOAD: state_next = ST_TDIV;
      ST_TDIV:  state_next = div_rsp.done ? ST_SLOAD : ST_TDIV;
      ST_SLOAD: state_next = ST_SMUL;
      ST_SMUL:  state_next = (lane == 2'd2) ? ST_DONE : ST_SLOAD;
      ST_DONE:  state_next = res_load ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    acc_ctrl.acc  = pix_accept &&
                    (pix_data.cmd == CMD_PIXEL || pix_data.cmd == CMD_LAST);
    acc_ctrl.clear = (state == ST_TEST);
    mul_gain      = (state == ST_NUM);
    res_load      = (state == ST_DONE) && (!res_valid || !res_stall);
    div_req.start = (state == ST_TLOAD);
    div_req.num   = (DIV_NW'(num) << 9) + DIV_NW'(den);
    div_req.den   = {den, 1'b0};
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Frame-end datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_DEN) begin
      den  <= mul_p[SUM_W-1:0];
      blob <= pix_count;
    end
    if (state == ST_IDLE && pix_accept && pix_data.cmd == CMD_TICK) begin
      blob <= '0;
    end
    if (state == ST_TEST) begin
      mag <= mag_w;
      neg <= diff_w[SUM_W];
    end
    if (state == ST_NUM) begin
      num <= mul_p[NUM_W-1:0];
    end
    if (state == ST_SLOAD) begin
      sm_neg <= sm_n[SM_NW-1];
      sm_r   <= sm_m + SM_MW'(SM_RND);
    end
  end

  // Lane counter over x, y, turn
  always_ff @(posedge clk) begin
    if (rst || state == ST_IDLE) begin
      lane <= '0;
    end else if (state == ST_SMUL) begin
      lane <= lane + 1'b1;
    end
  end

  // Targets and smoothed values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        tgt[i]    <= '0;
        smooth[i] <= '0;
      end
    end else begin
      if (state == ST_TEST) begin
        if (centred) begin
          tgt[0] <= $signed({1'b0, forward_speed, 8'h00});
          tgt[1] <= -$signed({1'b0, forward_speed, 8'h00});
          tgt[2] <= '0;
        end else begin
          tgt[0] <= '0;
          tgt[1] <= '0;
          if (!steer) begin
            tgt[2] <= $signed({1'b0, turn_gain, 8'h00});
          end
        end
      end
      if (state == ST_TDIV && div_rsp.done) begin
        tgt[2] <= turn_w;
      end
      if (state == ST_SMUL) begin
        smooth[lane] <= sm_neg ? $signed(sm_qn) : $signed(sm_q);
      end
    end
  end

  // Output register: load when free, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data.drive_x     <= smooth[0];
      res_data.drive_y     <= smooth[1];
      res_data.drive_turn  <= smooth[2];
      res_data.blob_pixels <= blob;
    end
  end

  `CBS_ASSERT_NEXT(a_last_starts_frame, pix_accept && pix_data.cmd == CMD_LAST, state == ST_DEN)
  `CBS_ASSERT_NOW(a_div_done_awaited, div_rsp.done, state == ST_TDIV)
  `CBS_ASSERT_NEXT(a_frame_cleared, state == ST_TEST, col_sum == '0 && pix_count == '0)
  `CBS_ASSERT_NOW(a_lane_range, state == ST_SLOAD || state == ST_SMUL, lane != 2'd3)

endmodule
`default_nettype wire
